/* rtl/beg_pkg.sv */
`default_nettype none
package beg_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 1'b1;

    // event mask bits
    localparam int unsigned MB_PRESS    = 0;
    localparam int unsigned MB_RELEASE  = 1;
    localparam int unsigned MB_CLICK    = 2;
    localparam int unsigned MB_LONG     = 3;
    localparam int unsigned MB_REPEAT   = 4;
    localparam int unsigned MB_TOGGLE   = 5;
    localparam int unsigned MB_TOUCH    = 6;
    localparam int unsigned MB_USERDRAW = 7;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PRESS   = 3'd1;
    localparam logic [2:0] EV_RELEASE = 3'd2;
    localparam logic [2:0] EV_CLICK   = 3'd3;
    localparam logic [2:0] EV_LONG    = 3'd4;

    // led styles
    localparam logic [1:0] ST_DEFAULT  = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_TOUCH    = 2'd2;
    localparam logic [1:0] ST_SELECTED = 2'd3;

    localparam logic [31:0] REP_MAX_SPAN = 32'd1000;
    localparam logic [6:0]  REP_SLOW     = 7'd100;
    // 90 * d / 1000 as d * 47187 / 2^19, exact for d up to 1000
    localparam logic [25:0] REP_RECIP    = 26'd47187;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT0,
        S_EMIT1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic eval;
        logic show0;
        logic show1;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] count;
    } sts_t;

    typedef struct packed {
        logic [4:0] which_button;
        logic [2:0] event_code;
        logic       led_write;
        logic [1:0] led_style;
        logic       is_selected;
        logic       was_touched;
    } res_t;

endpackage
`default_nettype wire

/* rtl/beg_ctrl.sv */
`default_nettype none
module beg_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_fire,
    input  wire beg_pkg::sts_t sts,
    output beg_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid,
    output logic               out_last
);
    import beg_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_READ;
            S_READ:  state_next = S_EVAL;
            S_EVAL:
            begin
                if (sts.count == 2'd0) state_next = S_IDLE;
                else                   state_next = S_EMIT0;
            end
            S_EMIT0:
            begin
                if (out_fire)
                    state_next = (sts.count == 2'd2) ? S_EMIT1 : S_IDLE;
            end
            S_EMIT1: if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_last  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = 1'b1;
            end
            S_READ:  ;
            S_EVAL:  cmd.eval = 1'b1;
            S_EMIT0:
            begin
                out_valid = 1'b1;
                out_last  = (sts.count != 2'd2);
                cmd.show0 = 1'b1;
            end
            S_EMIT1:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                cmd.show1 = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/beg_dp.sv */
`default_nettype none
module beg_dp #(
    parameter int unsigned NUM_BUTTONS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire beg_pkg::cmd_t cmd,
    input  wire logic          in_fire,
    input  wire logic          in_kind,
    input  wire logic [4:0]    in_btn,
    input  wire logic          in_down,
    input  wire logic [31:0]   in_time,
    input  wire logic [7:0]    in_mask,
    input  wire logic          cfg_fire,
    input  wire logic [beg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]   cfg_data,
    output beg_pkg::sts_t      sts,
    output beg_pkg::res_t      res
);
    import beg_pkg::*;

    localparam int unsigned IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [15:0] long_reg, rdelay_reg;
    logic [NUM_BUTTONS-1:0] pressed_reg, touched_reg, selected_reg, armed_reg;
    logic [7:0]  mask_mem [NUM_BUTTONS];
    logic [31:0] pstamp_mem [NUM_BUTTONS];
    logic [31:0] rstamp_mem [NUM_BUTTONS];

    // latched item
    logic        kind_reg, down_reg, inr_reg;
    logic [4:0]  btn_reg;
    logic [31:0] now_reg;
    logic [7:0]  nmask_reg;
    logic [IW-1:0] idx;
    // registered memory reads
    logic [7:0]  m_reg;
    logic [31:0] pst_reg, rst_reg;
    // results
    res_t r0_reg, r1_reg;
    logic [1:0] cnt_reg;

    assign idx = IW'(btn_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg   <= 16'd800;
            rdelay_reg <= 16'd300;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:   long_reg   <= cfg_data;
                REG_REPEAT_DELAY: rdelay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in && in_fire)
        begin
            kind_reg  <= in_kind;
            btn_reg   <= in_btn;
            down_reg  <= in_down;
            now_reg   <= in_time;
            nmask_reg <= in_mask;
            inr_reg   <= (32'(in_btn) < NUM_BUTTONS);
        end
    end

    // registered memory reads
    always_ff @(posedge clk)
    begin
        m_reg   <= mask_mem[idx];
        pst_reg <= pstamp_mem[idx];
        rst_reg <= rstamp_mem[idx];
    end

    // evaluation
    logic [31:0] dif, rdif, dd, over;
    logic [9:0]  dcl;
    logic [25:0] prod;
    logic [6:0]  interval;
    logic        pr, arm, sel_n;
    logic [1:0]  cnt;
    res_t        a, b;
    logic        wr_mask, wr_stamp, wr_rstamp;
    logic        set_p, clr_p, set_arm, clr_arm, flip_sel;
    logic        lw;
    logic [1:0]  st;

    assign dif  = now_reg - pst_reg;
    assign rdif = now_reg - rst_reg;
    assign dd   = dif - 32'(rdelay_reg);
    assign over = (dd > REP_MAX_SPAN) ? REP_MAX_SPAN : dd;
    assign dcl  = over[9:0];
    // interval reduction by reciprocal multiply
    assign prod = 26'(dcl) * REP_RECIP;

    always_comb
    begin
        pr = pressed_reg[idx];
        arm = armed_reg[idx];
        sel_n = selected_reg[idx];
        interval = REP_SLOW - prod[25:19];
        cnt = 2'd0;
        a = '0;
        b = '0;
        a.which_button = btn_reg;
        b.which_button = btn_reg;
        wr_mask = 1'b0; wr_stamp = 1'b0; wr_rstamp = 1'b0;
        set_p = 1'b0; clr_p = 1'b0; set_arm = 1'b0; clr_arm = 1'b0;
        flip_sel = 1'b0;
        lw = 1'b0;
        st = ST_DEFAULT;
        if (inr_reg)
        begin
            if (!kind_reg)
            begin
                wr_mask = 1'b1;
                clr_arm = 1'b1;
                if (!nmask_reg[MB_USERDRAW])
                begin
                    cnt = 2'd1;
                    a.led_write = 1'b1;
                end
            end
            else if (m_reg != 8'd0)
            begin
                if (down_reg != pr)
                begin
                    if (down_reg)
                    begin
                        lw = !m_reg[MB_REPEAT];
                        set_p = 1'b1; set_arm = 1'b1;
                        wr_stamp = 1'b1; wr_rstamp = 1'b1;
                        if (m_reg[MB_PRESS] || lw)
                        begin
                            cnt = 2'd1;
                            a.event_code = m_reg[MB_PRESS] ? EV_PRESS : EV_NONE;
                            a.led_write = lw;
                            a.led_style = lw ? ST_PRESSED : ST_DEFAULT;
                        end
                    end
                    else
                    begin
                        clr_p = 1'b1;
                        if (arm)
                        begin
                            lw = !m_reg[MB_USERDRAW];
                            st = m_reg[MB_TOUCH] ? ST_TOUCH : ST_DEFAULT;
                            clr_arm = 1'b1;
                            if (lw && m_reg[MB_TOGGLE])
                            begin
                                flip_sel = 1'b1;
                                sel_n = !sel_n;
                                if (sel_n) st = ST_SELECTED;
                            end
                            a.led_write = lw;
                            a.led_style = lw ? st : ST_DEFAULT;
                            if (m_reg[MB_RELEASE] && m_reg[MB_CLICK])
                            begin
                                cnt = 2'd2;
                                a.event_code = EV_RELEASE;
                                b.event_code = EV_CLICK;
                            end
                            else if (m_reg[MB_RELEASE])
                            begin
                                cnt = 2'd1;
                                a.event_code = EV_RELEASE;
                            end
                            else if (m_reg[MB_CLICK])
                            begin
                                cnt = 2'd1;
                                a.event_code = EV_CLICK;
                            end
                            else if (lw)
                                cnt = 2'd1;
                        end
                    end
                end
                else if (down_reg && arm)
                begin
                    if (m_reg[MB_REPEAT] && dif > 32'(rdelay_reg))
                    begin
                        if (rdif > 32'(interval))
                        begin
                            wr_rstamp = 1'b1;
                            cnt = 2'd1;
                            a.event_code = EV_PRESS;
                        end
                    end
                    else if (m_reg[MB_LONG] && dif > 32'(long_reg))
                    begin
                        lw = !m_reg[MB_USERDRAW];
                        clr_arm = 1'b1;
                        cnt = 2'd1;
                        a.event_code = EV_LONG;
                        a.led_write = lw;
                        a.led_style = (lw && m_reg[MB_TOUCH]) ? ST_TOUCH : ST_DEFAULT;
                    end
                end
            end
        end
        a.is_selected = sel_n;
        b.is_selected = sel_n;
        a.was_touched = touched_reg[idx] | set_p;
        b.was_touched = touched_reg[idx] | set_p;
    end

    // flag updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg  <= '0;
            touched_reg  <= '0;
            selected_reg <= '0;
            armed_reg    <= '0;
            cnt_reg      <= 2'd0;
        end
        else if (cmd.eval)
        begin
            cnt_reg <= cnt;
            if (set_p)
            begin
                pressed_reg[idx] <= 1'b1;
                touched_reg[idx] <= 1'b1;
            end
            if (clr_p)    pressed_reg[idx]  <= 1'b0;
            if (set_arm)  armed_reg[idx]    <= 1'b1;
            if (clr_arm)  armed_reg[idx]    <= 1'b0;
            if (flip_sel) selected_reg[idx] <= sel_n;
        end
    end

    // mask and stamp stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
                mask_mem[i] <= 8'd0;
        end
        else if (cmd.eval && wr_mask)
            mask_mem[idx] <= nmask_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            if (wr_stamp)  pstamp_mem[idx] <= now_reg;
            if (wr_rstamp) rstamp_mem[idx] <= now_reg;
            r0_reg <= a;
            r1_reg <= b;
        end
    end

    // live count during evaluation, held count while emitting
    assign sts.count = cmd.eval ? cnt : cnt_reg;
    assign res = cmd.show1 ? r1_reg : r0_reg;
endmodule
`default_nettype wire

/* rtl/button_event_generator.sv */
`default_nettype none
// Button event generator.
// Input stream s_axis: one word is a mask write (kind 0) or a scan sample
// (kind 1) of one button. Output stream m_axis: zero, one or two result
// words per input word; tlast marks the final word of each input.
// cfg channel: index 0 long_press_ms, index 1 repeat_delay_ms; write only
// while idle.
// Sequence: an input word is taken in the idle state; the state read and
// the evaluation follow in turn, then the results are shown. The
// controller steps through capture, store read, evaluate and emit, and
// takes no new input until the last result word of the one before is taken.
// While the receiver stalls, the current result holds and no input is taken.
// Reset clears all flags and masks, restores register defaults; stamps
// are only used after a press has written them.
module button_event_generator #(
    parameter int unsigned NUM_BUTTONS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] button, [5] down, [37:6] time_ms, [45:38] event_mask, rest zero
    input  wire logic [47:0] s_axis_tdata,
    // [0] kind
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] which_button, [7:5] event_code, [8] led_write, [10:9] led_style,
    // [11] is_selected, [12] was_touched, rest zero
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [beg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    import beg_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t res;
    logic in_fire, out_fire;

    assign cfg_ready = 1'b1;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    beg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_last(m_axis_tlast)
    );

    beg_dp #(.NUM_BUTTONS(NUM_BUTTONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_fire(in_fire),
        .in_kind(s_axis_tuser), .in_btn(s_axis_tdata[4:0]),
        .in_down(s_axis_tdata[5]), .in_time(s_axis_tdata[37:6]),
        .in_mask(s_axis_tdata[45:38]),
        .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .sts(sts), .res(res)
    );

    assign m_axis_tdata = {3'd0, res.was_touched, res.is_selected, res.led_style,
                           res.led_write, res.event_code, res.which_button};

    // no input taken while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // an accepted input never yields output next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !m_axis_tvalid) else $error("output too early");
endmodule
`default_nettype wire

/* bench/tb_button_event_generator.sv */
`default_nettype none
module tb_button_event_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import beg_pkg::*;

    localparam int NBTN = 32;

    // mask bit values
    localparam logic [7:0] MK_PRESS    = 8'(1 << MB_PRESS);
    localparam logic [7:0] MK_RELEASE  = 8'(1 << MB_RELEASE);
    localparam logic [7:0] MK_CLICK    = 8'(1 << MB_CLICK);
    localparam logic [7:0] MK_LONG     = 8'(1 << MB_LONG);
    localparam logic [7:0] MK_REPEAT   = 8'(1 << MB_REPEAT);
    localparam logic [7:0] MK_TOGGLE   = 8'(1 << MB_TOGGLE);
    localparam logic [7:0] MK_TOUCH    = 8'(1 << MB_TOUCH);
    localparam logic [7:0] MK_USERDRAW = 8'(1 << MB_USERDRAW);

    localparam logic KIND_MASK = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct {
        res_t r;
        logic last;
    } event_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    button_event_generator #(.NUM_BUTTONS(NBTN)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // shadow of the button array
    logic [15:0] long_ms;
    logic [15:0] rep_delay_ms;
    logic        pressed_q  [NBTN];
    logic        touched_q  [NBTN];
    logic        selected_q [NBTN];
    logic        armed_q    [NBTN];
    logic [31:0] press_t    [NBTN];
    logic [31:0] repeat_t   [NBTN];
    logic [7:0]  mask_q     [NBTN];

    event_word_t pending_events[$];
    int errors = 0;
    int words_seen = 0;
    int items_sent = 0;
    int rx_hold = 0;
    bit no_idle = 1'b0;
    logic [31:0] clock_ms;

    // ---------------------------------------------------------------
    // predictor
    function automatic logic [1:0] idle_style(logic [7:0] m);
        return (m & MK_TOUCH) ? ST_TOUCH : ST_DEFAULT;
    endfunction

    task automatic predict_events(logic kind, logic [4:0] btn, logic dn,
                                  logic [31:0] now, logic [7:0] newmask);
        res_t        outs[2];
        int          n;
        logic [4:0]  b;
        logic [7:0]  m;
        logic        lw;
        logic [1:0]  st;
        logic [31:0] dif;
        logic [31:0] d;
        logic [31:0] interval;
        event_word_t w;
        n = 0;
        b = btn;
        if (btn >= NBTN)
            return;
        m = mask_q[b];
        if (kind == KIND_MASK)
        begin
            mask_q[b] = newmask;
            armed_q[b] = 1'b0;
            if (!(newmask & MK_USERDRAW))
                outs[n++] = '{b, EV_NONE, 1'b1, ST_DEFAULT, 1'b0, 1'b0};
        end
        else if (m == 0)
            return;
        else if (dn != pressed_q[b])
        begin
            if (dn)
            begin
                lw = !(m & MK_REPEAT);
                pressed_q[b] = 1'b1;
                touched_q[b] = 1'b1;
                press_t[b] = now;
                repeat_t[b] = now;
                armed_q[b] = 1'b1;
                if ((m & MK_PRESS) || lw)
                    outs[n++] = '{b, (m & MK_PRESS) ? EV_PRESS : EV_NONE, lw,
                                  lw ? ST_PRESSED : ST_DEFAULT, 1'b0, 1'b0};
            end
            else
            begin
                pressed_q[b] = 1'b0;
                if (armed_q[b])
                begin
                    lw = !(m & MK_USERDRAW);
                    st = idle_style(m);
                    armed_q[b] = 1'b0;
                    if (lw && (m & MK_TOGGLE))
                    begin
                        selected_q[b] = !selected_q[b];
                        if (selected_q[b])
                            st = ST_SELECTED;
                    end
                    if (m & MK_RELEASE)
                    begin
                        outs[n++] = '{b, EV_RELEASE, lw, lw ? st : ST_DEFAULT, 1'b0, 1'b0};
                        lw = 1'b0;
                    end
                    if (m & MK_CLICK)
                    begin
                        outs[n++] = '{b, EV_CLICK, lw, lw ? st : ST_DEFAULT, 1'b0, 1'b0};
                        lw = 1'b0;
                    end
                    if (lw)
                        outs[n++] = '{b, EV_NONE, 1'b1, st, 1'b0, 1'b0};
                end
            end
        end
        else if (dn && armed_q[b])
        begin
            dif = now - press_t[b];
            if ((m & MK_REPEAT) && dif > rep_delay_ms)
            begin
                d = dif - rep_delay_ms;
                if (d > 1000)
                    d = 1000;
                interval = 100 - (90 * d) / 1000;
                if (now - repeat_t[b] > interval)
                begin
                    repeat_t[b] = now;
                    outs[n++] = '{b, EV_PRESS, 1'b0, ST_DEFAULT, 1'b0, 1'b0};
                end
            end
            else if ((m & MK_LONG) && dif > long_ms)
            begin
                lw = !(m & MK_USERDRAW);
                armed_q[b] = 1'b0;
                outs[n++] = '{b, EV_LONG, lw, lw ? idle_style(m) : ST_DEFAULT,
                              1'b0, 1'b0};
            end
        end
        for (int k = 0; k < n; k++)
        begin
            w.r = outs[k];
            w.r.is_selected = selected_q[b];
            w.r.was_touched = touched_q[b];
            w.last = (k == n - 1);
            pending_events.push_back(w);
        end
    endtask

    // ---------------------------------------------------------------
    // input side
    task automatic send_word(logic kind, logic [4:0] btn, logic dn,
                             logic [31:0] now, logic [7:0] m);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {2'b0, m, now, dn, btn};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predict_events(kind, btn, dn, now, m);
        items_sent++;
    endtask

    task automatic set_mask(int btn, logic [7:0] m);
        send_word(KIND_MASK, 5'(btn), 1'($urandom), $urandom, m);
    endtask

    task automatic scan(int btn, logic dn, logic [31:0] now);
        send_word(KIND_SCAN, 5'(btn), dn, now, 8'($urandom));
    endtask

    // stop offering and wait for every result, then let the pipe settle
    task automatic drain;
        @(posedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_LONG_PRESS)
            long_ms = val;
        else
            rep_delay_ms = val;
    endtask

    // ---------------------------------------------------------------
    // output side: random stalls, long hold on request
    initial
    begin
        int n;
        event_word_t w;
        res_t got;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 17);
            if (rx_hold > 0)
            begin
                n = rx_hold;
                rx_hold = 0;
            end
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            got = '{m_axis_tdata[4:0], m_axis_tdata[7:5], m_axis_tdata[8],
                    m_axis_tdata[10:9], m_axis_tdata[11], m_axis_tdata[12]};
            words_seen++;
            if (pending_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual %h last %b",
                         $realtime, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                w = pending_events.pop_front();
                if (got != w.r || m_axis_tlast !== w.last || m_axis_tdata[15:13] !== 0)
                begin
                    errors++;
                    $display("%0t: mismatch: expected btn %0d ev %0d lw %b st %0d sel %b",
                             $realtime, w.r.which_button, w.r.event_code, w.r.led_write,
                             w.r.led_style, w.r.is_selected);
                    $display("    touched %b last %b; actual tdata %h last %b",
                             w.r.was_touched, w.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    task automatic test_directed;
        // zero mask is ignored
        scan(3, 1'b1, 32'd10);
        scan(8, 1'b1, 32'd10);
        // press, release and click events, no repeat: press, release + click with toggle
        set_mask(0, MK_PRESS | MK_RELEASE | MK_CLICK | MK_TOGGLE | MK_TOUCH);
        scan(0, 1'b1, 32'd100);
        scan(0, 1'b0, 32'd150);
        scan(0, 1'b1, 32'd200);
        scan(0, 1'b0, 32'd250);
        // LED only, no events enabled
        set_mask(1, MK_TOUCH);
        scan(1, 1'b1, 32'd0);
        scan(1, 1'b0, 32'd5);
        // long click, user drawn; then release of the disarmed button
        set_mask(2, MK_LONG | MK_USERDRAW | MK_CLICK);
        scan(2, 1'b1, 32'hFFFF_FF00);
        scan(2, 1'b1, 32'h0000_0300);
        scan(2, 1'b1, 32'h0000_0900);
        scan(2, 1'b0, 32'h0000_0A00);
        // auto repeat across the time wrap
        set_mask(31, MK_PRESS | MK_REPEAT | MK_LONG);
        scan(31, 1'b1, 32'hFFFF_FFF0);
        scan(31, 1'b1, 32'h0000_0200);
        scan(31, 1'b1, 32'h0000_0280);
        scan(31, 1'b1, 32'h0000_0800);
        scan(31, 1'b1, 32'h0000_0810);
        scan(31, 1'b0, 32'h0000_0900);
        set_mask(31, 8'h00);
    endtask

    // well-formed press / hold / release runs with random masks and times
    task automatic run_press_cycles(int runs);
        int b;
        int holds;
        for (int r = 0; r < runs; r++)
        begin
            b = $urandom_range(0, NBTN - 1);
            if ($urandom_range(0, 3) == 0)
                set_mask(b, $urandom_range(0, 15) == 0 ? 8'h00 : 8'($urandom));
            clock_ms += $urandom_range(0, 300);
            scan(b, 1'b1, clock_ms);
            holds = $urandom_range(0, 6);
            for (int h = 0; h < holds; h++)
            begin
                clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 1200)
                                                      : $urandom_range(0, 150);
                scan(b, 1'b1, clock_ms);
            end
            clock_ms += $urandom_range(0, 200);
            // occasional noise: duplicate levels, stray buttons
            if ($urandom_range(0, 7) == 0)
                scan($urandom_range(0, NBTN - 1), 1'($urandom), $urandom);
            scan(b, 1'b0, clock_ms);
        end
    endtask

    task automatic test_registers;
        write_reg(REG_LONG_PRESS, 16'd0);
        write_reg(REG_REPEAT_DELAY, 16'd0);
        run_press_cycles(25);
        write_reg(REG_LONG_PRESS, 16'hFFFF);
        write_reg(REG_REPEAT_DELAY, 16'hFFFF);
        run_press_cycles(25);
        write_reg(REG_LONG_PRESS, 16'd400);
        write_reg(REG_REPEAT_DELAY, 16'd150);
        run_press_cycles(25);
    endtask

    task automatic test_random;
        for (int i = 0; i < 8; i++)
        begin
            no_idle = (i % 4 == 3);
            run_press_cycles(20);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure;
        drain();
        rx_hold = 400;
        no_idle = 1'b1;
        for (int i = 0; i < NBTN; i++)
            set_mask(i, 8'($urandom) & ~MK_USERDRAW);
        no_idle = 1'b0;
        drain();
    endtask

    initial
    begin
        long_ms = 16'd800;
        rep_delay_ms = 16'd300;
        for (int i = 0; i < NBTN; i++)
        begin
            pressed_q[i] = 0; touched_q[i] = 0; selected_q[i] = 0;
            armed_q[i] = 0; mask_q[i] = 0; press_t[i] = 0; repeat_t[i] = 0;
        end
        clock_ms = $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_registers();
        test_random();
        write_reg(REG_LONG_PRESS, 16'd800);
        write_reg(REG_REPEAT_DELAY, 16'd300);
        run_press_cycles(20);
        drain();

        $display("Covered %0d input words and %0d result words: masks, presses,", items_sent,
                 words_seen);
        $display("releases, toggles, long clicks, auto repeat, time wrap, register extremes.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
